// ===== rtl/core/sobob_pkg.sv =====
// ----------------------------------------------------------------------------
// sobob_pkg
// Shared widths, register indexes and small helpers for the Sobel
// orientation binner.
// ----------------------------------------------------------------------------
package sobob_pkg;

   localparam int MaxWidth  = 1024;
   localparam int MaxHeight = 1024;
   localparam int MinDim    = 3;

   localparam int ColW  = $clog2(MaxWidth);
   localparam int RowW  = $clog2(MaxHeight);
   localparam int CfgW  = 11;
   localparam int PixW  = 8;
   localparam int BinW  = 4;
   localparam int MagW  = 11;
   localparam int AddrW = 3;
   localparam int DataW = 32;

   // wide enough for a register value, the clamped width and height
   localparam int DimW0 = (ColW + 1 > CfgW) ? ColW + 1 : CfgW;
   localparam int DimW  = (RowW + 1 > DimW0) ? RowW + 1 : DimW0;

   // register index, taken from address bit 2
   localparam logic RegImageWidth  = 1'b0;
   localparam logic RegImageHeight = 1'b1;

   localparam int ResetDim = 600;

   typedef logic [PixW-1:0] pix_type;
   typedef logic [CfgW-1:0] cfg_type;
   typedef logic [BinW-1:0] bin_type;
   typedef logic [MagW-1:0] mag_type;
   typedef logic [DimW-1:0] dim_type;

   // clamp a register value to MinDim..hi
   function automatic dim_type clamp_dim(input cfg_type v, input dim_type hi);
      dim_type x;
      x = DimW'(v);
      if (x < DimW'(MinDim)) begin
         return DimW'(MinDim);
      end else if (x > hi) begin
         return hi;
      end
      return x;
   endfunction

endpackage

// ===== rtl/core/sobel_orientation_binner.sv =====
// ----------------------------------------------------------------------------
// sobel_orientation_binner
// Sobel gradient with 30-degree orientation bins and integer magnitude.
// ----------------------------------------------------------------------------
// Sequence: an accepted pixel is read in StRead, and an interior pixel's result
//   word is registered from StDone after StMul and StRoot; border pixels give no word.
// Throughput: a new pixel is taken only while idle, so each interior pixel
//   holds the input through the shared 12x12 multiplier (4 passes), the
//   one-bit-per-cycle square root (11 passes) and the output handshake.
// Reset: synchronous; clears counters, window and control. Registers return
//   to 600 x 600. The line memories are not cleared.
// ----------------------------------------------------------------------------
module sobel_orientation_binner (
   input  logic                             clock,
   input  logic                             reset,
   // pixel input channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  sobob_pkg::pix_type               req_pixel,
   // result channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output sobob_pkg::bin_type               rsp_direction_bin,
   output sobob_pkg::mag_type               rsp_magnitude,
   output logic                             rsp_frame_end,
   // register port
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [sobob_pkg::AddrW-1:0]      paddr,
   input  logic [sobob_pkg::DataW-1:0]      pwdata,
   output logic [sobob_pkg::DataW-1:0]      prdata,
   output logic                             pready
);
   import sobob_pkg::*;

   // Sequencer codes
   localparam logic [2:0] StIdle = 3'd0;
   localparam logic [2:0] StRead = 3'd1;
   localparam logic [2:0] StMul  = 3'd2;
   localparam logic [2:0] StRoot = 3'd3;
   localparam logic [2:0] StDone = 3'd4;

   localparam int          StepW     = 4;
   localparam logic [StepW-1:0] MulLast  = StepW'(3);
   localparam logic [StepW-1:0] RootLast = StepW'(MagW - 1);

   // multiplier passes
   localparam logic [StepW-1:0] PassGx = StepW'(0);
   localparam logic [StepW-1:0] PassGy = StepW'(1);
   localparam logic [StepW-1:0] PassLo = StepW'(2);
   localparam logic [StepW-1:0] PassA  = StepW'(3);

   localparam int SqW  = 22;            // gx^2 + gy^2, lo^2, 3a^2
   localparam int RemW = MagW + 3;

   // ------------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------------
   logic [2:0]        state_ff, state_in;
   logic [StepW-1:0]  step_ff, step_in;
   cfg_type           width_ff, height_ff;
   logic [ColW-1:0]   col_ff, col_in;
   logic [RowW-1:0]   row_ff, row_in;
   pix_type           win_ff [6];
   pix_type           pix_ff;
   pix_type           rd_a_ff, rd_b_ff;      // row above, two rows above
   logic              last_ff;
   logic signed [10:0] gx_ff, gy_ff;
   logic [SqW-1:0]    sq_ff;                 // radicand, shifts out 2 bits a step
   logic [SqW-1:0]    losq_ff, a3_ff;
   logic [RemW-1:0]   rem_ff;
   mag_type           root_ff;
   logic              rsp_valid_ff;
   bin_type           rsp_bin_ff;
   mag_type           rsp_mag_ff;
   logic              rsp_end_ff;

   // line memories
   pix_type           line_a_mem [MaxWidth];
   pix_type           line_b_mem [MaxWidth];

   // ------------------------------------------------------------------------
   // Register port: address bit 2 selects the register
   // ------------------------------------------------------------------------
   logic cfg_wr;
   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite;
   assign prdata = (paddr[2] == RegImageHeight) ? DataW'(height_ff) : DataW'(width_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CfgW'(ResetDim);
         height_ff <= CfgW'(ResetDim);
      end else if (cfg_wr) begin
         if (paddr[2] == RegImageWidth) begin
            width_ff <= pwdata[CfgW-1:0];
         end else begin
            height_ff <= pwdata[CfgW-1:0];
         end
      end
   end

   dim_type w_eff, h_eff;
   assign w_eff = clamp_dim(width_ff, DimW'(MaxWidth));
   assign h_eff = clamp_dim(height_ff, DimW'(MaxHeight));

   // ------------------------------------------------------------------------
   // Handshakes
   // ------------------------------------------------------------------------
   logic req_acc, out_load;
   assign req_stall = (state_ff != StIdle);
   assign req_acc   = req_valid && !req_stall;
   assign out_load  = (state_ff == StDone) && (!rsp_valid_ff || !rsp_stall);

   // ------------------------------------------------------------------------
   // Line memories: read at accept, write back the shifted column in StRead
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (req_acc) begin
         rd_a_ff <= line_a_mem[col_ff];
         rd_b_ff <= line_b_mem[col_ff];
      end
      if (state_ff == StRead) begin
         line_a_mem[col_ff] <= pix_ff;
         line_b_mem[col_ff] <= rd_a_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Window and gradients (StRead)
   // ------------------------------------------------------------------------
   logic [9:0]         sum_r, sum_l, sum_t, sum_b;
   logic signed [10:0] gx_w, gy_w;
   logic [DimW-1:0]    col_next, row_next;
   logic               col_wrap, row_wrap, interior;

   // column: tl/ml/bl = win 0..2, tc/mc/bc = win 3..5, tr/mr/br = mem/mem/pixel
   assign sum_r = {2'b0, rd_b_ff} + {1'b0, rd_a_ff, 1'b0} + {2'b0, pix_ff};
   assign sum_l = {2'b0, win_ff[0]} + {1'b0, win_ff[1], 1'b0} + {2'b0, win_ff[2]};
   assign sum_t = {2'b0, win_ff[0]} + {1'b0, win_ff[3], 1'b0} + {2'b0, rd_b_ff};
   assign sum_b = {2'b0, win_ff[2]} + {1'b0, win_ff[5], 1'b0} + {2'b0, pix_ff};
   assign gx_w  = $signed({1'b0, sum_r}) - $signed({1'b0, sum_l});
   assign gy_w  = $signed({1'b0, sum_t}) - $signed({1'b0, sum_b});

   assign col_next = DimW'(col_ff) + DimW'(1);
   assign row_next = DimW'(row_ff) + DimW'(1);
   assign col_wrap = (col_next >= w_eff);
   assign row_wrap = (row_next >= h_eff);
   assign interior = (row_ff >= RowW'(2)) && (col_ff >= ColW'(2));

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (cfg_wr) begin
         // restart the frame on any register write
         col_in = '0;
         row_in = '0;
      end else if (state_ff == StRead) begin
         if (col_wrap) begin
            col_in = '0;
            row_in = row_wrap ? '0 : row_next[RowW-1:0];
         end else begin
            col_in = col_next[ColW-1:0];
         end
      end
   end

   // ------------------------------------------------------------------------
   // Shared multiplier: gx^2, gy^2, lo^2, a^2 over four passes
   // ------------------------------------------------------------------------
   logic [10:0]        a_abs, b_abs;
   logic [9:0]         a_mag, b_mag;
   logic signed [11:0] lo_w, mul_op;
   logic signed [23:0] prod;
   logic [SqW:0]       a3_w;

   assign a_abs = gx_ff[10] ? 11'(-gx_ff) : 11'(gx_ff);
   assign b_abs = gy_ff[10] ? 11'(-gy_ff) : 11'(gy_ff);
   assign a_mag = a_abs[9:0];
   assign b_mag = b_abs[9:0];
   assign lo_w  = $signed({1'b0, a_mag, 1'b0}) - $signed({2'b0, b_mag});

   always_comb begin
      unique case (step_ff)
         PassGx:  mul_op = 12'(gx_ff);
         PassGy:  mul_op = 12'(gy_ff);
         PassLo:  mul_op = lo_w;
         default: mul_op = $signed({2'b0, a_mag});
      endcase
   end
   assign prod = mul_op * mul_op;
   assign a3_w = {1'b0, prod[SqW-1:0]} + {prod[SqW-1:0], 1'b0};

   // ------------------------------------------------------------------------
   // Square root: one result bit per cycle
   // ------------------------------------------------------------------------
   logic [RemW-1:0] rem_sh, trial;
   logic            take;
   assign rem_sh = {rem_ff[RemW-3:0], sq_ff[SqW-1:SqW-2]};
   assign trial  = RemW'({root_ff, 2'b01});
   assign take   = (rem_sh >= trial);

   // ------------------------------------------------------------------------
   // Sector from exact compares against tan 15 / tan 45 / tan 75
   // ------------------------------------------------------------------------
   logic       steep_gt, below15, above75;
   logic [1:0] s_up, s_dn;
   bin_type    sector;

   assign steep_gt = (losq_ff > a3_ff);
   assign below15  = ({1'b0, a_mag, 1'b0} > {2'b0, b_mag}) && steep_gt;
   assign above75  = ({1'b0, a_mag, 1'b0} < {2'b0, b_mag}) && steep_gt;

   always_comb begin
      priority if (below15) begin
         s_up = 2'd0; s_dn = 2'd0;
      end else if (above75) begin
         s_up = 2'd3; s_dn = 2'd3;
      end else if (b_mag < a_mag) begin
         s_up = 2'd1; s_dn = 2'd1;
      end else if (b_mag == a_mag) begin
         // exact diagonal goes to the sector above
         s_up = 2'd2; s_dn = 2'd1;
      end else begin
         s_up = 2'd2; s_dn = 2'd2;
      end
   end

   always_comb begin
      if (a_mag == '0 && b_mag == '0) begin
         sector = '0;
      end else begin
         unique case ({gx_ff[10], gy_ff[10]})
            2'b00:   sector = BinW'(s_up);
            2'b10:   sector = BinW'(6) - BinW'(s_dn);
            2'b11:   sector = BinW'(6) + BinW'(s_up);
            default: sector = (s_dn == 2'd0) ? '0 : BinW'(12) - BinW'(s_dn);
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         StIdle: begin
            if (req_acc) state_in = StRead;
         end
         StRead: begin
            step_in  = '0;
            state_in = interior ? StMul : StIdle;
         end
         StMul: begin
            if (step_ff == MulLast) begin
               step_in  = '0;
               state_in = StRoot;
            end else begin
               step_in = step_ff + StepW'(1);
            end
         end
         StRoot: begin
            if (step_ff == RootLast) begin
               state_in = StDone;
            end else begin
               step_in = step_ff + StepW'(1);
            end
         end
         StDone: begin
            if (out_load) state_in = StIdle;
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         step_ff  <= '0;
         col_ff   <= '0;
         row_ff   <= '0;
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         if (state_ff == StRead) begin
            // advance the window by one column
            win_ff[0] <= win_ff[3];
            win_ff[1] <= win_ff[4];
            win_ff[2] <= win_ff[5];
            win_ff[3] <= rd_b_ff;
            win_ff[4] <= rd_a_ff;
            win_ff[5] <= pix_ff;
         end
      end
   end

   // datapath, no reset
   always_ff @(posedge clock) begin
      if (req_acc) begin
         pix_ff <= req_pixel;
      end
      unique case (state_ff)
         StRead: begin
            gx_ff   <= gx_w;
            gy_ff   <= gy_w;
            last_ff <= col_wrap && row_wrap;
            rem_ff  <= '0;
            root_ff <= '0;
         end
         StMul: begin
            unique case (step_ff)
               PassGx:  sq_ff   <= prod[SqW-1:0];
               PassGy:  sq_ff   <= sq_ff + prod[SqW-1:0];
               PassLo:  losq_ff <= prod[SqW-1:0];
               PassA:   a3_ff   <= a3_w[SqW-1:0];
               default: ;
            endcase
         end
         StRoot: begin
            sq_ff   <= {sq_ff[SqW-3:0], 2'b00};
            rem_ff  <= take ? rem_sh - trial : rem_sh;
            root_ff <= {root_ff[MagW-2:0], take};
         end
         default: ;
      endcase
   end

   // ------------------------------------------------------------------------
   // Output register
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_bin_ff <= sector;
         rsp_mag_ff <= root_ff;
         rsp_end_ff <= last_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_direction_bin = rsp_bin_ff;
   assign rsp_magnitude     = rsp_mag_ff;
   assign rsp_frame_end     = rsp_end_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   a_accept_reads: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> (state_ff == StRead))
      else $error("accepted word did not enter the read cycle");

   a_col_in_row: assert property (@(posedge clock) disable iff (reset)
      (state_ff == StRead) |-> (DimW'(col_ff) < w_eff))
      else $error("column counter beyond row width");

   a_root_steps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == StRoot) |-> (step_ff <= RootLast))
      else $error("square root step out of range");

   a_bin_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_bin_ff < BinW'(12)))
      else $error("direction bin out of range");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_valid_ff && (state_ff == StIdle))
      else $error("finished word not presented");

endmodule
